// ===== rtl/pts_pkg.sv =====
// Shared types, sizes and codes of the periodic task slot scheduler.
package pts_pkg;

    localparam int GROUPS = 4;
    localparam int SLOTS  = 16;
    localparam int CELLS  = GROUPS * SLOTS;

    localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PROC_EN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUPS  = 1'd1;

    typedef enum logic [2:0] {
        ACT_CREATE   = 3'd0,
        ACT_QUEUE    = 3'd1,
        ACT_PROCESS  = 3'd2,
        ACT_SET_EN   = 3'd3,
        ACT_MARK_DEL = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_DISABLED = 3'd1,
        STAT_ABSENT   = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_REPLY,
        OP_CREATE,
        OP_QUEUE,
        OP_SCAN,
        OP_SET_EN,
        OP_DELETE
    } op_t;

    typedef struct packed {
        op_t         op;
        kind_t       kind;
        status_t     status;
        logic [3:0]  slot;
        logic [1:0]  grp;
        logic        grp_ok;
        logic [31:0] now;
        logic [31:0] ival;
        logic        flag;
    } cmd_t;

    typedef struct packed {
        kind_t      kind;
        status_t    status;
        logic [3:0] slot;
        logic       periodic;
        logic       freed;
        logic [3:0] cur_slot;
        logic       cur_valid;
        logic       last;
    } res_t;

    function automatic logic [CELL_W-1:0] cell_of(input logic [GRP_W-1:0] g,
                                                  input logic [SLOT_W-1:0] s);
        cell_of = CELL_W'(int'(g) * SLOTS + int'(s));
    endfunction

endpackage

// ===== rtl/pts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== rtl/pts_front.sv =====
// Front end: accepts requests and classifies them against the configuration.
module pts_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pts_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [pts_pkg::IN_USER_W-1:0] s_tuser,
    input  logic                          proc_en,
    input  logic [3:0]                    groups_present,
    input  logic                          q_full,
    output logic                          q_push,
    output pts_pkg::cmd_t                 q_entry
);
    import pts_pkg::*;

    action_t    act;
    logic [1:0] grp;
    logic       grp_ok;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign act      = action_t'(s_tuser);
    assign grp      = s_tdata[1:0];
    assign grp_ok   = (int'(grp) < GROUPS) && groups_present[grp];

    always_comb
    begin
        q_entry        = '0;
        q_entry.grp    = grp;
        q_entry.grp_ok = grp_ok;
        q_entry.now    = s_tdata[37:6];
        q_entry.ival   = s_tdata[69:38];
        q_entry.flag   = s_tdata[70];
        q_entry.op     = OP_REPLY;
        q_entry.kind   = KIND_ACK;
        q_entry.status = STAT_OK;
        q_entry.slot   = 4'd0;
        unique case (act)
            ACT_CREATE, ACT_QUEUE:
            begin
                if (grp_ok)
                begin
                    q_entry.op = (act == ACT_CREATE) ? OP_CREATE : OP_QUEUE;
                end
                else
                begin
                    q_entry.status = STAT_ABSENT;
                end
            end
            ACT_PROCESS:
            begin
                q_entry.kind = KIND_DONE;
                if (!proc_en)
                begin
                    q_entry.status = STAT_DISABLED;
                end
                else if (!grp_ok)
                begin
                    q_entry.status = STAT_ABSENT;
                end
                else
                begin
                    q_entry.op = OP_SCAN;
                end
            end
            ACT_SET_EN, ACT_MARK_DEL:
            begin
                q_entry.slot = s_tdata[5:2];
                if (grp_ok)
                begin
                    q_entry.op = (act == ACT_SET_EN) ? OP_SET_EN : OP_DELETE;
                end
                else
                begin
                    q_entry.status = STAT_ABSENT;
                end
            end
            default:
            begin
                q_entry.op = OP_REPLY;
            end
        endcase
    end
endmodule

// ===== rtl/pts_queue.sv =====
// Short request queue between the front end and the slot engine.
module pts_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pts_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output pts_pkg::cmd_t head
);
    import pts_pkg::*;

    cmd_t               store [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;

    assign full       = (int'(count_reg) == QDEPTH);
    assign head_valid = (count_reg != '0);
    assign head       = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ===== rtl/pts_engine.sv =====
// Slot engine: carries out queued requests on the slot tables and drives the results.
module pts_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  pts_pkg::cmd_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output pts_pkg::res_t out_res
);
    import pts_pkg::*;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_DONE
    } eng_state_t;

    eng_state_t         state_reg, state_next;
    logic [CELLS-1:0]   used_reg, used_next;
    logic [CELLS-1:0]   en_reg, en_next;
    logic [CELLS-1:0]   per_reg, per_next;
    logic [CELLS-1:0]   del_reg, del_next;
    logic [SLOT_W-1:0]  cur_slot_reg [GROUPS];
    logic [SLOT_W-1:0]  cur_slot_next [GROUPS];
    logic [GROUPS-1:0]  cur_valid_reg, cur_valid_next;
    logic [SLOT_W:0]    rd_idx_reg, rd_idx_next;
    logic               ev_valid_reg, ev_valid_next;
    logic [SLOT_W-1:0]  ev_idx_reg, ev_idx_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_reg, out_next;

    logic [GRP_W-1:0]   gi;
    logic               out_free;
    logic               found;
    logic [SLOT_W-1:0]  free_idx;
    logic [CELL_W-1:0]  free_cell;
    logic               slot_in;
    logic [CELL_W-1:0]  addr_cell;
    logic [CELL_W-1:0]  ev_cell;
    logic               fire;
    logic [3:0]         cur_slot_out;
    logic               cur_valid_out;

    logic               ram_rd_en;
    logic [CELL_W-1:0]  ram_rd_addr;
    logic               due_we;
    logic [CELL_W-1:0]  due_waddr;
    logic [31:0]        due_wdata;
    logic               period_we;
    logic [31:0]        due_rd;
    logic [31:0]        period_rd;

    pts_ram #(.WIDTH(32), .DEPTH(CELLS)) u_due (
        .clk     (clk),
        .wr_en   (due_we),
        .wr_addr (due_waddr),
        .wr_data (due_wdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (due_rd)
    );

    pts_ram #(.WIDTH(32), .DEPTH(CELLS)) u_period (
        .clk     (clk),
        .wr_en   (period_we),
        .wr_addr (free_cell),
        .wr_data (head.ival),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (period_rd)
    );

    assign out_valid     = out_valid_reg;
    assign out_res       = out_reg;
    assign gi            = GRP_W'(head.grp);
    assign out_free      = !out_valid_reg || out_ready;
    assign free_cell     = cell_of(gi, free_idx);
    assign slot_in       = (int'(head.slot) < SLOTS);
    assign addr_cell     = cell_of(gi, SLOT_W'(head.slot));
    assign ev_cell       = cell_of(gi, ev_idx_reg);
    assign ram_rd_addr   = cell_of(gi, rd_idx_reg[SLOT_W-1:0]);
    assign fire          = ev_valid_reg && used_reg[ev_cell] && en_reg[ev_cell]
                           && (head.now >= due_rd);
    assign cur_slot_out  = head.grp_ok ? 4'(cur_slot_reg[gi]) : 4'd0;
    assign cur_valid_out = head.grp_ok && cur_valid_reg[gi];

    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[cell_of(gi, SLOT_W'(i))])
            begin
                found    = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        en_next        = en_reg;
        per_next       = per_reg;
        del_next       = del_reg;
        cur_slot_next  = cur_slot_reg;
        cur_valid_next = cur_valid_reg;
        rd_idx_next    = rd_idx_reg;
        ev_valid_next  = ev_valid_reg;
        ev_idx_next    = ev_idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pop            = 1'b0;
        ram_rd_en      = 1'b0;
        due_we         = 1'b0;
        due_waddr      = free_cell;
        due_wdata      = head.now + head.ival;
        period_we      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ENG_IDLE:
            begin
                if (head_valid && head.op == OP_SCAN)
                begin
                    state_next    = ENG_SCAN;
                    rd_idx_next   = '0;
                    ev_valid_next = 1'b0;
                end
                else if (head_valid && out_free)
                begin
                    pop                = 1'b1;
                    out_valid_next     = 1'b1;
                    out_next.kind      = head.kind;
                    out_next.status    = head.status;
                    out_next.slot      = head.slot;
                    out_next.periodic  = 1'b0;
                    out_next.freed     = 1'b0;
                    out_next.cur_slot  = cur_slot_out;
                    out_next.cur_valid = cur_valid_out;
                    out_next.last      = 1'b1;
                    case (head.op)
                        OP_CREATE, OP_QUEUE:
                        begin
                            if (!found)
                            begin
                                out_next.status = STAT_FULL;
                            end
                            else
                            begin
                                used_next[free_cell] = 1'b1;
                                del_next[free_cell]  = 1'b0;
                                en_next[free_cell]   = (head.op == OP_QUEUE);
                                per_next[free_cell]  = (head.op == OP_CREATE);
                                period_we            = 1'b1;
                                due_we               = 1'b1;
                                if (head.op == OP_CREATE)
                                begin
                                    due_wdata = 32'd0;
                                end
                                out_next.slot = 4'(free_idx);
                            end
                        end
                        OP_SET_EN, OP_DELETE:
                        begin
                            if (!slot_in || !used_reg[addr_cell])
                            begin
                                out_next.status = STAT_EMPTY;
                            end
                            else if (head.op == OP_SET_EN)
                            begin
                                en_next[addr_cell] = head.flag;
                            end
                            else
                            begin
                                del_next[addr_cell] = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_next.kind = head.kind;
                        end
                    endcase
                end
            end
            ENG_SCAN:
            begin
                if (!fire || out_free)
                begin
                    if (fire)
                    begin
                        out_valid_next     = 1'b1;
                        out_next.kind      = KIND_FIRED;
                        out_next.status    = STAT_OK;
                        out_next.slot      = 4'(ev_idx_reg);
                        out_next.periodic  = per_reg[ev_cell];
                        out_next.freed     = !per_reg[ev_cell] || del_reg[ev_cell];
                        out_next.cur_slot  = 4'(ev_idx_reg);
                        out_next.cur_valid = 1'b1;
                        out_next.last      = 1'b0;
                        cur_slot_next[gi]  = ev_idx_reg;
                        cur_valid_next[gi] = 1'b1;
                        if (per_reg[ev_cell] && !del_reg[ev_cell])
                        begin
                            due_we    = 1'b1;
                            due_waddr = ev_cell;
                            due_wdata = head.now + period_rd;
                        end
                        else
                        begin
                            used_next[ev_cell] = 1'b0;
                            en_next[ev_cell]   = 1'b0;
                            per_next[ev_cell]  = 1'b0;
                            del_next[ev_cell]  = 1'b0;
                        end
                    end
                    if (int'(rd_idx_reg) < SLOTS)
                    begin
                        ram_rd_en     = 1'b1;
                        ev_valid_next = 1'b1;
                        ev_idx_next   = rd_idx_reg[SLOT_W-1:0];
                        rd_idx_next   = rd_idx_reg + 1'b1;
                    end
                    else
                    begin
                        ev_valid_next = 1'b0;
                        state_next    = ENG_DONE;
                    end
                end
            end
            ENG_DONE:
            begin
                if (out_free)
                begin
                    pop                = 1'b1;
                    out_valid_next     = 1'b1;
                    out_next.kind      = KIND_DONE;
                    out_next.status    = STAT_OK;
                    out_next.slot      = 4'd0;
                    out_next.periodic  = 1'b0;
                    out_next.freed     = 1'b0;
                    out_next.cur_slot  = cur_slot_out;
                    out_next.cur_valid = cur_valid_out;
                    out_next.last      = 1'b1;
                    state_next         = ENG_IDLE;
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_IDLE;
            used_reg      <= '0;
            en_reg        <= '0;
            per_reg       <= '0;
            del_reg       <= '0;
            cur_slot_reg  <= '{default: '0};
            cur_valid_reg <= '0;
            rd_idx_reg    <= '0;
            ev_valid_reg  <= 1'b0;
            ev_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            en_reg        <= en_next;
            per_reg       <= per_next;
            del_reg       <= del_next;
            cur_slot_reg  <= cur_slot_next;
            cur_valid_reg <= cur_valid_next;
            rd_idx_reg    <= rd_idx_next;
            ev_valid_reg  <= ev_valid_next;
            ev_idx_reg    <= ev_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end
endmodule

// ===== rtl/periodic_task_slot_scheduler.sv =====
// Top level of the periodic task slot scheduler.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser action, s_tdata request fields
// m_*       out  m_tvalid/m_tready  m_tuser kind, m_tdata result, m_tlast
// cfg_*     in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// A single-result request is carried out in the engine cycle that takes it from the queue.
// In a process request the engine reads one slot a cycle from the due-time and period
// memories, pausing while a fired result cannot leave, and then gives the done result.
// Reset clears all slot marks, current-slot records and control registers at once.
// Up to two requests wait in the queue while the engine or the output stalls.
module periodic_task_slot_scheduler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // group[1:0], slot[5:2], now_ms[37:6], interval_ms[69:38], flag_value[70]
    input  logic [pts_pkg::IN_DATA_W-1:0]  s_tdata,
    // action[2:0]
    input  logic [pts_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[2:0], result_slot[6:3], fired_periodic[7], slot_freed[8],
    // current_slot[12:9], current_valid[13]
    output logic [pts_pkg::OUT_DATA_W-1:0] m_tdata,
    // result_kind[1:0]
    output logic [pts_pkg::OUT_USER_W-1:0] m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pts_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pts_pkg::*;

    logic       proc_en_reg, proc_en_next;
    logic [3:0] groups_reg, groups_next;
    logic       q_full;
    logic       q_push;
    cmd_t       q_entry;
    logic       q_pop;
    logic       head_valid;
    cmd_t       head;
    res_t       res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        proc_en_next = proc_en_reg;
        groups_next  = groups_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PROC_EN: proc_en_next = cfg_data[0];
                CFG_GROUPS:  groups_next  = cfg_data[3:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_en_reg <= 1'b0;
            groups_reg  <= '0;
        end
        else
        begin
            proc_en_reg <= proc_en_next;
            groups_reg  <= groups_next;
        end
    end

    pts_front u_front (
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .proc_en        (proc_en_reg),
        .groups_present (groups_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (q_entry)
    );

    pts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    pts_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res)
    );

    assign m_tuser = res.kind;
    assign m_tlast = res.last;
    assign m_tdata = {2'b00, res.cur_valid, res.cur_slot, res.freed, res.periodic,
                      res.slot, res.status};
endmodule

// ===== rtl/pts_checker.sv =====
// Port-level assertions for the periodic task slot scheduler, bound to the top level.
module pts_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pts_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [pts_pkg::OUT_USER_W-1:0] m_tuser,
    input logic                           m_tlast
);
    import pts_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("Result changed while stalled.");

    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_FIRED |-> !m_tlast)
        else $error("A fired result closed a request.");

    a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_FIRED |-> m_tlast)
        else $error("An acknowledge or done result was not last.");

    a_fired_current: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_FIRED |->
            m_tdata[2:0] == STAT_OK && m_tdata[13] && m_tdata[12:9] == m_tdata[6:3])
        else $error("Fired result does not match the current slot.");

    a_single_freed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_FIRED && !m_tdata[7] |-> m_tdata[8])
        else $error("A single-shot slot was kept after firing.");
endmodule

bind periodic_task_slot_scheduler pts_checker u_pts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
